>>> design/assert_macros.svh
// assertion macros used by frustum_cull_tester_top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_CLK(lbl, clk_s, rst_ns, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_ns) (prop)) else $error(msg);

// checked on every edge, reset included
`define ASSERT_CLK_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) (prop)) else $error(msg);

`endif

>>> design/fct_pkg.sv
// shared types and constants for the frustum cull tester
`default_nettype none

package fct_pkg;

  localparam int COORD_W   = 32;
  localparam int OP_W      = 2;
  localparam int IDX_W     = 3;
  localparam int FRAC_BITS = 16;
  localparam int PROD_W    = 2 * COORD_W;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int SUM_W     = PROD_W + 2;

  typedef logic [OP_W-1:0]           op_t;
  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [SUM_W-1:0]   sum_t;

  localparam op_t OP_LOAD   = 2'd0;
  localparam op_t OP_SPHERE = 2'd1;
  localparam op_t OP_BOX    = 2'd2;

endpackage

`default_nettype wire

>>> design/fct_in_if.sv
// query/load channel into the cull tester
`default_nettype none

interface fct_in_if;
  import fct_pkg::*;

  logic   valid;
  logic   ready;
  op_t    op;
  logic [IDX_W-1:0] plane_index;
  coord_t x0;
  coord_t y0;
  coord_t z0;
  coord_t x1;
  coord_t y1;
  coord_t z1;
  coord_t scalar;

  modport source (
    output valid, op, plane_index, x0, y0, z0, x1, y1, z1, scalar,
    input  ready
  );
  modport sink (
    input  valid, op, plane_index, x0, y0, z0, x1, y1, z1, scalar,
    output ready
  );
endinterface

`default_nettype wire

>>> design/fct_out_if.sv
// result channel out of the cull tester
`default_nettype none

interface fct_out_if;
  logic valid;
  logic ready;
  logic culled;

  modport source (output valid, culled, input ready);
  modport sink   (input valid, culled, output ready);
endinterface

`default_nettype wire

>>> design/frustum_cull_tester_top.sv
// frustum cull tester: plane store, sphere and box tests against all planes
// usage:
//   in_chan carries one item per transfer: op 0 loads plane slot plane_index
//   with normal x0/y0/z0 and offset scalar, op 1 tests a sphere (centre
//   x0/y0/z0, radius scalar), op 2 tests a box (min x0/y0/z0, max x1/y1/z1).
//   out_chan returns one culled bit per item, in order; loads and op 3
//   return 0. a load takes effect for every item accepted after it.
//   each item passes the input register, product register and result register.
//   one item per cycle while out_chan does not stall, a rate set by the
//   per-plane multipliers that all planes run side by side.
//   the distance n.p + d is summed exactly at 2*FRAC_BITS fraction bits.
//   reset (synchronous, active low) clears all planes to zero and empties
//   the pipeline. when out_chan stalls, empty stages still fill, so up to
//   three items are held before in_chan.ready drops.
`default_nettype none
`include "assert_macros.svh"

module frustum_cull_tester_top #(
  parameter int NUM_PLANES = 6
) (
  input  logic      clk,
  input  logic      rst_n,
  fct_in_if.sink    in_chan,
  fct_out_if.source out_chan
);
  import fct_pkg::*;

  // plane store
  coord_t plane_nx_r  [NUM_PLANES];
  coord_t plane_ny_r  [NUM_PLANES];
  coord_t plane_nz_r  [NUM_PLANES];
  coord_t plane_off_r [NUM_PLANES];

  // stage 1: input register
  logic   s1_v_r;
  op_t    s1_op_r;
  coord_t s1_x0_r, s1_y0_r, s1_z0_r;
  coord_t s1_x1_r, s1_y1_r, s1_z1_r;
  coord_t s1_sc_r;

  // stage 2: products
  logic  s2_v_r;
  logic  s2_test_r;
  prod_t s2_px_r   [NUM_PLANES];
  prod_t s2_py_r   [NUM_PLANES];
  prod_t s2_pz_r   [NUM_PLANES];
  diff_t s2_diff_r [NUM_PLANES];

  // stage 3: result register
  logic out_valid_r;
  logic out_culled_r;

  logic out_free, s2_free, s1_free, in_acc, load_acc;

  prod_t px_nxt   [NUM_PLANES];
  prod_t py_nxt   [NUM_PLANES];
  prod_t pz_nxt   [NUM_PLANES];
  diff_t diff_nxt [NUM_PLANES];
  logic  test_nxt;
  logic [NUM_PLANES-1:0] outside;
  logic  culled_nxt;

  assign out_free = !out_valid_r || out_chan.ready;
  assign s2_free  = !s2_v_r || out_free;
  assign s1_free  = !s1_v_r || s2_free;
  assign in_chan.ready = s1_free;
  assign in_acc   = in_chan.valid && s1_free;
  assign load_acc = in_acc && (in_chan.op == OP_LOAD);

  assign out_chan.valid  = out_valid_r;
  assign out_chan.culled = out_culled_r;

  // plane writes land at the load's transfer edge
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_PLANES; i++) begin
        plane_nx_r[i]  <= '0;
        plane_ny_r[i]  <= '0;
        plane_nz_r[i]  <= '0;
        plane_off_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NUM_PLANES; i++) begin
        if (load_acc && (int'(in_chan.plane_index) == i)) begin
          plane_nx_r[i]  <= in_chan.x0;
          plane_ny_r[i]  <= in_chan.y0;
          plane_nz_r[i]  <= in_chan.z0;
          plane_off_r[i] <= in_chan.scalar;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_free) begin
      s1_v_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r <= in_chan.op;
      s1_x0_r <= in_chan.x0;
      s1_y0_r <= in_chan.y0;
      s1_z0_r <= in_chan.z0;
      s1_x1_r <= in_chan.x1;
      s1_y1_r <= in_chan.y1;
      s1_z1_r <= in_chan.z1;
      s1_sc_r <= in_chan.scalar;
    end
  end

  // stage 1 logic: vertex select, one multiplier per plane and axis
  always_comb begin
    logic   is_box;
    coord_t vx, vy, vz, bias;
    is_box   = (s1_op_r == OP_BOX);
    test_nxt = (s1_op_r == OP_SPHERE) || is_box;
    bias     = (s1_op_r == OP_SPHERE) ? s1_sc_r : '0;
    for (int i = 0; i < NUM_PLANES; i++) begin
      // box takes the minimum where the normal points positive
      vx = (is_box && !(plane_nx_r[i] > 0)) ? s1_x1_r : s1_x0_r;
      vy = (is_box && !(plane_ny_r[i] > 0)) ? s1_y1_r : s1_y0_r;
      vz = (is_box && !(plane_nz_r[i] > 0)) ? s1_z1_r : s1_z0_r;
      px_nxt[i]   = PROD_W'(plane_nx_r[i]) * PROD_W'(vx);
      py_nxt[i]   = PROD_W'(plane_ny_r[i]) * PROD_W'(vy);
      pz_nxt[i]   = PROD_W'(plane_nz_r[i]) * PROD_W'(vz);
      diff_nxt[i] = DIFF_W'(plane_off_r[i]) - DIFF_W'(bias);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_free) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r && s2_free) begin
      s2_test_r <= test_nxt;
      for (int i = 0; i < NUM_PLANES; i++) begin
        s2_px_r[i]   <= px_nxt[i];
        s2_py_r[i]   <= py_nxt[i];
        s2_pz_r[i]   <= pz_nxt[i];
        s2_diff_r[i] <= diff_nxt[i];
      end
    end
  end

  // stage 2 logic: exact distance per plane, strictly positive means outside
  always_comb begin
    sum_t plane_sum;
    for (int i = 0; i < NUM_PLANES; i++) begin
      plane_sum = SUM_W'(s2_px_r[i]) + SUM_W'(s2_py_r[i]) + SUM_W'(s2_pz_r[i])
                + (SUM_W'(s2_diff_r[i]) <<< FRAC_BITS);
      outside[i] = !plane_sum[SUM_W-1] && (plane_sum != '0);
    end
    culled_nxt = s2_test_r && (|outside);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s2_v_r) begin
      out_culled_r <= culled_nxt;
    end
  end

  `ASSERT_CLK(a_in_fills_s1, clk, rst_n, in_acc |=> s1_v_r, "accepted item lost at stage 1")
  `ASSERT_CLK(a_s2_to_out, clk, rst_n, (s2_v_r && out_free) |=> out_valid_r, "stage 2 item not passed to result register")
  `ASSERT_CLK(a_nontest_zero, clk, rst_n, (s2_v_r && out_free && !s2_test_r) |=> !out_culled_r, "load or unused op gave culled")
  `ASSERT_CLK_ALWAYS(a_reset_empty, clk, !rst_n |=> (!out_valid_r && !s1_v_r && !s2_v_r), "pipeline not empty after reset")

endmodule

`default_nettype wire

>>> dv/frustum_cull_tester_top_tb.sv
// testbench for frustum_cull_tester_top: random and directed plane loads and cull queries
`timescale 1ns / 100ps

module frustum_cull_tester_top_tb;
  import fct_pkg::*;

  localparam int NPL = 6;
  localparam op_t OP_UNUSED = 2'd3;
  localparam coord_t C_MIN = 32'sh8000_0000;
  localparam coord_t C_MAX = 32'sh7fff_ffff;
  localparam coord_t C_ONE = 32'sh0001_0000;
  localparam int RAND_PER_PHASE = 600;

  typedef struct {
    op_t              op;
    logic [IDX_W-1:0] idx;
    coord_t           x0, y0, z0, x1, y1, z1, scalar;
  } cull_item_t;

  // mirrors the plane store and predicts the culled bit of every accepted item
  class cull_scoreboard;
    coord_t nx[NPL], ny[NPL], nz[NPL], off[NPL];
    bit     culled_q[$];
    int     fails;
    int     seen;

    function new();
      for (int i = 0; i < NPL; i++) begin
        nx[i] = '0; ny[i] = '0; nz[i] = '0; off[i] = '0;
      end
      fails = 0;
      seen = 0;
    endfunction

    // exact n.p + (d - bias) > 0 at 2*FRAC_BITS fraction bits
    function bit beyond_plane(int i, coord_t px, coord_t py, coord_t pz, coord_t bias);
      logic signed [71:0] acc;
      acc = nx[i] * px + ny[i] * py + nz[i] * pz + ((off[i] - bias) <<< FRAC_BITS);
      return acc > 0;
    endfunction

    function void note_input(cull_item_t it);
      bit     hit;
      coord_t vx, vy, vz;
      hit = 1'b0;
      case (it.op)
        OP_LOAD: begin
          if (it.idx < NPL) begin
            nx[it.idx] = it.x0;
            ny[it.idx] = it.y0;
            nz[it.idx] = it.z0;
            off[it.idx] = it.scalar;
          end
        end
        OP_SPHERE: begin
          for (int i = 0; i < NPL; i++)
            if (beyond_plane(i, it.x0, it.y0, it.z0, it.scalar)) hit = 1'b1;
        end
        OP_BOX: begin
          for (int i = 0; i < NPL; i++) begin
            // nearest vertex: min where the normal points positive
            vx = (nx[i] > 0) ? it.x0 : it.x1;
            vy = (ny[i] > 0) ? it.y0 : it.y1;
            vz = (nz[i] > 0) ? it.z0 : it.z1;
            if (beyond_plane(i, vx, vy, vz, '0)) hit = 1'b1;
          end
        end
        default: ;
      endcase
      culled_q.push_back(hit);
    endfunction

    function void check_result(logic got);
      bit want;
      seen++;
      if (culled_q.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("result %0d arrived with nothing pending: culled=%0b", seen, got);
      end else begin
        want = culled_q.pop_front();
        if (got !== want) begin
          fails++;
          if (fails <= 10)
            $display("result %0d mismatch: expected culled=%0b, got %0b", seen, want, got);
        end
      end
    endfunction

    function int pending();
      return culled_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic out_hold;
  int   in_idle_pct;
  int   out_idle_pct;

  cull_scoreboard sb = new();

  fct_in_if  in_chan ();
  fct_out_if out_chan ();

  frustum_cull_tester_top #(.NUM_PLANES(NPL)) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan.sink),
    .out_chan (out_chan.source)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("frustum_cull_tester_top_tb: FAIL");
    $finish;
  end

  // result side: check each transfer, then pick next cycle's ready
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) sb.check_result(out_chan.culled);
    out_chan.ready <= !out_hold && ($urandom_range(99) >= out_idle_pct);
  end

  function automatic coord_t rand_coord();
    case ($urandom_range(9))
      0: return coord_t'($urandom);
      1: begin
        case ($urandom_range(3))
          0: return C_MIN;
          1: return C_MAX;
          2: return '0;
          default: return -1;
        endcase
      end
      default: return coord_t'(int'($urandom_range(2**21)) - 2**20);
    endcase
  endfunction

  function automatic cull_item_t rand_item();
    cull_item_t it;
    int pick;
    pick = $urandom_range(99);
    it.x0 = rand_coord(); it.y0 = rand_coord(); it.z0 = rand_coord();
    it.x1 = rand_coord(); it.y1 = rand_coord(); it.z1 = rand_coord();
    it.scalar = rand_coord();
    it.idx = IDX_W'($urandom_range(7));
    if (pick < 15) begin
      it.op = OP_LOAD;
      if ($urandom_range(9) < 8) it.idx = IDX_W'($urandom_range(NPL - 1));
      // inert plane: zero normal, non-positive offset, never culls a box
      if ($urandom_range(9) < 3) begin
        it.x0 = '0; it.y0 = '0; it.z0 = '0;
        it.scalar = coord_t'(-int'($urandom_range(2**20)));
      end
    end else if (pick < 55) begin
      it.op = OP_SPHERE;
      if ($urandom_range(3) == 0) it.scalar = coord_t'($urandom_range(2**30));
    end else if (pick < 95) begin
      it.op = OP_BOX;
    end else begin
      it.op = OP_UNUSED;
    end
    return it;
  endfunction

  task automatic send_item(cull_item_t it);
    while ($urandom_range(99) < in_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.op          <= it.op;
    in_chan.plane_index <= it.idx;
    in_chan.x0          <= it.x0;
    in_chan.y0          <= it.y0;
    in_chan.z0          <= it.z0;
    in_chan.x1          <= it.x1;
    in_chan.y1          <= it.y1;
    in_chan.z1          <= it.z1;
    in_chan.scalar      <= it.scalar;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    sb.note_input(it);
  endtask

  task automatic send_fields(op_t op, int idx, coord_t x0, coord_t y0, coord_t z0,
                             coord_t x1, coord_t y1, coord_t z1, coord_t sc);
    cull_item_t it;
    it.op = op; it.idx = IDX_W'(idx);
    it.x0 = x0; it.y0 = y0; it.z0 = z0;
    it.x1 = x1; it.y1 = y1; it.z1 = z1;
    it.scalar = sc;
    send_item(it);
  endtask

  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    rst_n               <= 1'b0;
    out_hold            <= 1'b0;
    in_idle_pct         <= 24;
    out_idle_pct        <= 46;
    in_chan.valid       <= 1'b0;
    in_chan.op          <= OP_LOAD;
    in_chan.plane_index <= '0;
    in_chan.x0          <= '0;
    in_chan.y0          <= '0;
    in_chan.z0          <= '0;
    in_chan.x1          <= '0;
    in_chan.y1          <= '0;
    in_chan.z1          <= '0;
    in_chan.scalar      <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // all planes still zero: sphere culled only for negative radius
    send_fields(OP_SPHERE, 0, C_MAX, C_MIN, '0, '0, '0, '0, -1);
    send_fields(OP_SPHERE, 0, C_MIN, C_MAX, C_ONE, '0, '0, '0, '0);
    send_fields(OP_SPHERE, 0, '0, '0, '0, '0, '0, '0, C_MIN);
    send_fields(OP_BOX, 0, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MAX);
    send_fields(OP_UNUSED, 7, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, C_MAX);
    // slots past the last plane are not written
    send_fields(OP_LOAD, 6, C_ONE, '0, '0, '0, '0, '0, C_MAX);
    send_fields(OP_LOAD, 7, C_MIN, C_MIN, C_MIN, '0, '0, '0, C_MAX);
    send_fields(OP_SPHERE, 0, '0, '0, '0, '0, '0, '0, '0);
    send_fields(OP_BOX, 0, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, '0);
    // extreme planes
    send_fields(OP_LOAD, 0, C_MAX, C_MIN, C_ONE, -1, -1, -1, C_MIN);
    send_fields(OP_LOAD, 1, C_MIN, C_MIN, C_MIN, '0, '0, '0, C_MAX);
    send_fields(OP_LOAD, 2, C_ONE, '0, '0, '0, '0, '0, -32'sh0005_0000);
    send_fields(OP_LOAD, 3, '0, -C_ONE, '0, '0, '0, '0, -32'sh0005_0000);
    send_fields(OP_LOAD, 4, '0, '0, C_MAX, '0, '0, '0, '0);
    send_fields(OP_LOAD, 5, '0, '0, '0, '0, '0, '0, -C_ONE);
    send_fields(OP_SPHERE, 0, 32'sh0006_0000, '0, '0, '0, '0, '0, 32'sh0000_8000);
    send_fields(OP_SPHERE, 0, 32'sh0006_0000, '0, '0, '0, '0, '0, 32'sh0002_0000);
    send_fields(OP_SPHERE, 0, C_MAX, C_MAX, C_MAX, '0, '0, '0, C_MIN);
    send_fields(OP_SPHERE, 0, C_MIN, C_MIN, C_MIN, '0, '0, '0, C_MAX);
    send_fields(OP_BOX, 0, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, '0);
    // inverted box: max below min on every axis
    send_fields(OP_BOX, 0, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, '0);
    send_fields(OP_BOX, 0, -C_ONE, -C_ONE, -C_ONE, C_ONE, C_ONE, C_ONE, C_MAX);
    send_fields(OP_LOAD, 1, '0, '0, '0, '0, '0, '0, '0);
    send_fields(OP_BOX, 0, 32'sh0006_0000, '0, '0, 32'sh0007_0000, '0, '0, '0);

    for (int n = 0; n < RAND_PER_PHASE; n++) begin
      if (n == 150) begin
        // long receiver stall so the pipeline fills and in_chan.ready drops
        fork
          begin
            out_hold <= 1'b1;
            repeat (80) @(posedge clk);
            out_hold <= 1'b0;
          end
        join_none
      end
      send_item(rand_item());
    end
    wait_drained();

    in_idle_pct  <= 46;
    out_idle_pct <= 24;
    for (int n = 0; n < RAND_PER_PHASE; n++) begin
      if (n == 300) wait_drained();
      send_item(rand_item());
    end
    wait_drained();

    in_idle_pct  <= 0;
    out_idle_pct <= 0;
    for (int n = 0; n < RAND_PER_PHASE; n++) send_item(rand_item());
    wait_drained();
    repeat (6) @(posedge clk);

    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("frustum_cull_tester_top_tb: PASS");
    end else begin
      $display("frustum_cull_tester_top_tb: FAIL");
    end
    $finish;
  end

endmodule
